// ===== rtl/lph_pkg.sv =====
// Shared command codes, status codes, field widths and hash constants.
package lph_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int KEY_IN_W = 64;
    localparam int VALUE_W  = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam int DJB2_SEED = 5381;
    localparam int DJB2_MULT = 33;

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// Linear-probe key/value table with DJB2 home slot, one slot memory read per probe.
// Flow: accept, then the DJB2 hash over the kept key bytes (up to KEY_BYTES), then the slots
//   are probed one at a time (the single read port of the slot memory), result registered.
// Clear writes one slot per cycle. The next item can be accepted as soon as the previous
//   result is registered, while that result may still wait.
// Reset: flags in memory are swept to zero; in_ready stays low meanwhile.
module linear_probe_hash_table #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lph_pkg::CMD_W-1:0]           command,
    input  logic [lph_pkg::KEY_IN_W-1:0]        key,
    input  logic [lph_pkg::VALUE_W-1:0]         value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lph_pkg::STATUS_W-1:0]        status,
    output logic [lph_pkg::VALUE_W-1:0]         value_out,
    output logic [$clog2(SLOTS)-1:0]            slot,
    output logic [$clog2(SLOTS+1)-1:0]          live_count
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int VW    = lph_pkg::VALUE_W;
    localparam int WW    = 2 + KEY_W + VW;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [CW-1:0] LAST_PROBE = CW'(SLOTS - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [SW-1:0]                probe_reg, probe_next;
    logic [CW-1:0]                n_reg, n_next;
    logic                         free_found_reg, free_found_next;
    logic [SW-1:0]                free_reg, free_next;
    logic [SW-1:0]                sweep_reg, sweep_next;

    logic [lph_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]             kept_reg, kept_next;
    logic [VW-1:0]                val_reg, val_next;

    logic                         out_valid_reg, out_valid_next;
    logic [lph_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [VW-1:0]                vout_reg, vout_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic [CW-1:0]                live_reg, live_next;

    logic [KEY_W-1:0]             kept_in;
    logic                         alive;
    logic                         accept;
    logic                         out_free;
    logic                         hash_done;
    logic [SW-1:0]                hash_home;

    logic                         we;
    logic [SW-1:0]                waddr;
    logic [WW-1:0]                wdata;
    logic [SW-1:0]                raddr;
    logic [WW-1:0]                rdata;

    logic                         w_used, w_tomb;
    logic [KEY_W-1:0]             w_key;
    logic [VW-1:0]                w_val;
    logic                         match, cur_free, stop, free_any;
    logic [SW-1:0]                free_slot, probe_inc, sweep_inc;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign value_out  = vout_reg;
    assign slot       = slot_reg;
    assign live_count = live_reg;

    // keep bytes up to the first zero byte, drop the rest
    always_comb
    begin
        alive   = 1'b1;
        kept_in = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            alive = alive && (key[lph_pkg::KEY_IN_W-1-8*i -: 8] != 8'd0);
            kept_in[KEY_W-1-8*i -: 8] = alive ? key[lph_pkg::KEY_IN_W-1-8*i -: 8] : 8'd0;
        end
    end

    lph_hash #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (command != lph_pkg::CMD_CLEAR)),
        .key_bytes (kept_in),
        .done      (hash_done),
        .home      (hash_home)
    );

    lph_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign w_used    = rdata[WW-1];
    assign w_tomb    = rdata[WW-2];
    assign w_key     = rdata[VW +: KEY_W];
    assign w_val     = rdata[VW-1:0];
    assign match     = w_used && !w_tomb && (w_key == kept_reg);
    assign cur_free  = !w_used || w_tomb;
    assign stop      = !w_used || match || (n_reg == LAST_PROBE);
    assign free_any  = free_found_reg || cur_free;
    assign free_slot = free_found_reg ? free_reg : probe_reg;
    assign probe_inc = (probe_reg == LAST_SLOT) ? '0 : probe_reg + 1'b1;
    assign sweep_inc = sweep_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        probe_next      = probe_reg;
        n_next          = n_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        sweep_next      = sweep_reg;
        cmd_next        = cmd_reg;
        kept_next       = kept_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        vout_next       = vout_reg;
        slot_next       = slot_reg;
        live_next       = live_reg;
        we              = 1'b0;
        waddr           = sweep_reg;
        wdata           = '0;
        raddr           = probe_reg;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                we = 1'b1;
                if (sweep_reg != LAST_SLOT)
                begin
                    sweep_next = sweep_inc;
                end
                else if (state_reg == S_INIT)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lph_pkg::ST_HIT;
                    vout_next      = '0;
                    slot_next      = '0;
                    live_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = command;
                    kept_next = kept_in;
                    val_next  = value;
                    if (command == lph_pkg::CMD_CLEAR)
                    begin
                        count_next = '0;
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    raddr           = hash_home;
                    probe_next      = hash_home;
                    n_next          = '0;
                    free_found_next = 1'b0;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!stop)
                begin
                    // advance to the next slot, reading it for the following cycle
                    free_found_next = free_any;
                    free_next       = free_slot;
                    probe_next      = probe_inc;
                    raddr           = probe_inc;
                    n_next          = n_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    vout_next      = '0;
                    slot_next      = '0;
                    status_next    = lph_pkg::ST_MISS;
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        lph_pkg::CMD_INSERT:
                        begin
                            wdata = {1'b1, 1'b0, kept_reg, val_reg};
                            if (match)
                            begin
                                we          = 1'b1;
                                waddr       = probe_reg;
                                status_next = lph_pkg::ST_UPDATED;
                                slot_next   = probe_reg;
                            end
                            else if (free_any)
                            begin
                                we          = 1'b1;
                                waddr       = free_slot;
                                count_next  = count_reg + 1'b1;
                                status_next = lph_pkg::ST_NEW;
                                slot_next   = free_slot;
                            end
                            else
                            begin
                                status_next = lph_pkg::ST_FULL;
                            end
                        end
                        lph_pkg::CMD_FIND:
                        begin
                            if (match)
                            begin
                                status_next = lph_pkg::ST_HIT;
                                slot_next   = probe_reg;
                                vout_next   = w_val;
                            end
                        end
                        lph_pkg::CMD_REMOVE:
                        begin
                            // leave a tombstone with its value zeroed
                            if (match)
                            begin
                                we          = 1'b1;
                                waddr       = probe_reg;
                                wdata       = {1'b1, 1'b1, w_key, {VW{1'b0}}};
                                status_next = lph_pkg::ST_HIT;
                                slot_next   = probe_reg;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = lph_pkg::ST_MISS;
                        end
                    endcase
                    live_next = count_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            count_reg      <= '0;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
            free_found_reg <= free_found_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        free_reg   <= free_next;
        cmd_reg    <= cmd_next;
        kept_reg   <= kept_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        slot_reg   <= slot_next;
        live_reg   <= live_next;
    end

endmodule

// ===== rtl/lph_ram.sv =====
// Simple dual-port slot memory: one write port, one registered read port.
module lph_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 98
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lph_hash.sv =====
// Iterative DJB2 home-slot unit: one key byte per cycle, reduced modulo the slot count.
module lph_hash #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [8*KEY_BYTES-1:0]   key_bytes,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] home
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int SW    = $clog2(SLOTS);
    localparam int XW    = SW + 6;
    localparam int IW    = $clog2(KEY_BYTES + 1);
    localparam logic [SW-1:0] HOME0 = SW'(lph_pkg::DJB2_SEED % SLOTS);

    logic              run_reg, run_next;
    logic [KEY_W-1:0]  shift_reg, shift_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [SW-1:0]     h_reg, h_next;
    logic [7:0]        top_byte;
    logic              fin;
    logic [XW-1:0]     x;

    assign top_byte = shift_reg[KEY_W-1 -: 8];
    assign fin      = (idx_reg == IW'(KEY_BYTES)) || (top_byte == 8'd0);
    assign done     = run_reg && fin;
    assign home     = h_reg;

    // h*33 + b stays below 64*SLOTS (for SLOTS of 8 or more), so six compare-subtract steps reduce it
    always_comb
    begin
        x = XW'(h_reg) * XW'(lph_pkg::DJB2_MULT) + XW'(top_byte);
        for (int j = 5; j >= 0; j--)
        begin
            if (x >= (XW'(SLOTS) << j))
            begin
                x = x - (XW'(SLOTS) << j);
            end
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        if (start)
        begin
            run_next   = 1'b1;
            shift_next = key_bytes;
            idx_next   = '0;
            h_next     = HOME0;
        end
        else if (run_reg)
        begin
            if (fin)
            begin
                run_next = 1'b0;
            end
            else
            begin
                shift_next = shift_reg << 8;
                idx_next   = idx_reg + 1'b1;
                h_next     = x[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        idx_reg   <= idx_next;
        h_reg     <= h_next;
    end

endmodule
